FILE: design/bls_pkg.sv
`timescale 1ns / 1ps

package bls_pkg;

    localparam int COORD_WIDTH_DEF = 11;
    localparam int COLOR_WIDTH     = 24;

    typedef logic [1:0] t_region;

    localparam t_region REG_SHALLOW_UP   = 2'd0;
    localparam t_region REG_SHALLOW_DOWN = 2'd1;
    localparam t_region REG_STEEP_UP     = 2'd2;
    localparam t_region REG_STEEP_DOWN   = 2'd3;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_STEP  = 1'b1;

endpackage

FILE: design/bresenham_line_stepper_top.sv
`timescale 1ns / 1ps

// Bresenham line stepper.
// The slave channel carries requests. tuser selects the kind: a start request
// loads two endpoints and produces nothing, a step request advances the line
// by one pixel and produces one pixel on the master channel while the line
// still has pixels left. A step request on an idle or finished line produces
// nothing. A start request always replaces the line in progress.
// The master channel carries the pixel column, row and the draw colour taken
// from the configuration register at the moment the step request is taken;
// tlast marks the pixel that reaches the end of the line.
// A pixel appears on the master side in the cycle after its step request is
// taken. One request is taken in every cycle, limited only by the single-entry
// output register: s_axis_tready is low only while a pixel is held there and
// the receiver keeps m_axis_tready low, so a stall on the master side holds
// the pixel and stops the slave side.
// After reset the line is idle, the output register is empty and the draw
// colour is zero. The colour register is written whenever i_cfg_wr_en is high.
module bresenham_line_stepper_top #(
    parameter int COORD_WIDTH = bls_pkg::COORD_WIDTH_DEF,
    parameter int IN_DW  = ((4 * COORD_WIDTH + 7) / 8) * 8,
    parameter int OUT_DW = ((2 * COORD_WIDTH + bls_pkg::COLOR_WIDTH + 7) / 8) * 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [bls_pkg::COLOR_WIDTH-1:0] i_cfg_wr_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // start_x, start_y, end_x, end_y from the lowest bit up
    input  logic [IN_DW-1:0]               s_axis_tdata,
    // req_type
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // pixel_x, pixel_y, pixel_color from the lowest bit up
    output logic [OUT_DW-1:0]              m_axis_tdata,
    output logic                           m_axis_tlast
);
    import bls_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int DW = COORD_WIDTH + 4;

    logic [COLOR_WIDTH-1:0] r_color;
    logic [W-1:0]           r_cur_x, r_cur_y, r_goal_x, r_goal_y;
    logic [W-1:0]           n_cur_x, n_cur_y, n_goal_x, n_goal_y;
    logic signed [W:0]      r_span_x, r_span_y, n_span_x, n_span_y;
    logic signed [DW-1:0]   r_decision, n_decision;
    t_region                r_region, n_region;
    logic                   r_busy, n_busy;

    logic                   r_out_valid;
    logic [W-1:0]           r_out_x, r_out_y;
    logic [COLOR_WIDTH-1:0] r_out_color;
    logic                   r_out_last;

    logic                   s_accept;
    logic                   emit;
    logic                   step_last;

    logic [W-1:0]           in_ax, in_ay, in_bx, in_by;
    logic [W-1:0]           ax, ay, bx, by;
    logic signed [W:0]      dx, dy, mag_y;
    logic signed [DW-1:0]   dx_ext, dy_ext;
    logic signed [DW-1:0]   sx_ext, sy_ext;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    assign in_ax = s_axis_tdata[W-1:0];
    assign in_ay = s_axis_tdata[2*W-1:W];
    assign in_bx = s_axis_tdata[3*W-1:2*W];
    assign in_by = s_axis_tdata[4*W-1:3*W];

    // Endpoints are ordered so that the line always runs left to right.
    always_comb begin
        if (in_bx < in_ax) begin
            ax = in_bx;
            ay = in_by;
            bx = in_ax;
            by = in_ay;
        end else begin
            ax = in_ax;
            ay = in_ay;
            bx = in_bx;
            by = in_by;
        end
    end

    assign dx     = $signed({1'b0, bx}) - $signed({1'b0, ax});
    assign dy     = $signed({1'b0, by}) - $signed({1'b0, ay});
    assign mag_y  = dy[W] ? -dy : dy;
    assign dx_ext = {{(DW-W-1){dx[W]}}, dx};
    assign dy_ext = {{(DW-W-1){dy[W]}}, dy};
    assign sx_ext = {{(DW-W-1){r_span_x[W]}}, r_span_x};
    assign sy_ext = {{(DW-W-1){r_span_y[W]}}, r_span_y};

    always_comb begin
        n_cur_x    = r_cur_x;
        n_cur_y    = r_cur_y;
        n_goal_x   = r_goal_x;
        n_goal_y   = r_goal_y;
        n_span_x   = r_span_x;
        n_span_y   = r_span_y;
        n_decision = r_decision;
        n_region   = r_region;
        n_busy     = r_busy;
        emit       = 1'b0;
        step_last  = 1'b0;
        if (s_accept) begin
            if (s_axis_tuser == REQ_START) begin
                n_cur_x  = ax;
                n_cur_y  = ay;
                n_goal_x = bx;
                n_goal_y = by;
                n_span_x = dx;
                n_span_y = dy;
                if (dx >= mag_y) begin
                    if (dy[W]) begin
                        n_region   = REG_SHALLOW_DOWN;
                        n_decision = (dy_ext <<< 1) + dx_ext;
                    end else begin
                        n_region   = REG_SHALLOW_UP;
                        n_decision = (dy_ext <<< 1) - dx_ext;
                    end
                    n_busy = ax < bx;
                end else begin
                    if (dy[W]) begin
                        n_region   = REG_STEEP_DOWN;
                        n_decision = dy_ext + (dx_ext <<< 1);
                        n_busy     = ay > by;
                    end else begin
                        n_region   = REG_STEEP_UP;
                        n_decision = dy_ext - (dx_ext <<< 1);
                        n_busy     = ay < by;
                    end
                end
            end else if (r_busy) begin
                emit = 1'b1;
                case (r_region)
                    REG_SHALLOW_UP: begin
                        if (r_decision < 0) begin
                            n_decision = r_decision + (sy_ext <<< 1);
                        end else begin
                            n_decision = r_decision + ((sy_ext - sx_ext) <<< 1);
                            n_cur_y    = r_cur_y + 1'b1;
                        end
                        n_cur_x   = r_cur_x + 1'b1;
                        step_last = n_cur_x >= r_goal_x;
                    end
                    REG_SHALLOW_DOWN: begin
                        if (r_decision < 0) begin
                            n_decision = r_decision + ((sy_ext + sx_ext) <<< 1);
                            n_cur_y    = r_cur_y - 1'b1;
                        end else begin
                            n_decision = r_decision + (sy_ext <<< 1);
                        end
                        n_cur_x   = r_cur_x + 1'b1;
                        step_last = n_cur_x >= r_goal_x;
                    end
                    REG_STEEP_UP: begin
                        if (r_decision < 0) begin
                            n_decision = r_decision + ((sy_ext - sx_ext) <<< 1);
                            n_cur_x    = r_cur_x + 1'b1;
                        end else begin
                            n_decision = r_decision - (sx_ext <<< 1);
                        end
                        n_cur_y   = r_cur_y + 1'b1;
                        step_last = n_cur_y >= r_goal_y;
                    end
                    default: begin
                        if (r_decision < 0) begin
                            n_decision = r_decision + (sx_ext <<< 1);
                        end else begin
                            n_decision = r_decision + ((sy_ext + sx_ext) <<< 1);
                            n_cur_x    = r_cur_x + 1'b1;
                        end
                        n_cur_y   = r_cur_y - 1'b1;
                        step_last = n_cur_y <= r_goal_y;
                    end
                endcase
                if (step_last) begin
                    n_busy = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color    <= '0;
            r_cur_x    <= '0;
            r_cur_y    <= '0;
            r_goal_x   <= '0;
            r_goal_y   <= '0;
            r_span_x   <= '0;
            r_span_y   <= '0;
            r_decision <= '0;
            r_region   <= REG_SHALLOW_UP;
            r_busy     <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_color <= i_cfg_wr_data;
            end
            r_cur_x    <= n_cur_x;
            r_cur_y    <= n_cur_y;
            r_goal_x   <= n_goal_x;
            r_goal_y   <= n_goal_y;
            r_span_x   <= n_span_x;
            r_span_y   <= n_span_y;
            r_decision <= n_decision;
            r_region   <= n_region;
            r_busy     <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_x     <= n_cur_x;
            r_out_y     <= n_cur_y;
            r_out_color <= r_color;
            r_out_last  <= step_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_DW'({r_out_color, r_out_y, r_out_x});
    assign m_axis_tlast  = r_out_last;

    // A start request leaves the output register empty once any held pixel is taken.
    a_start_no_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept && s_axis_tuser == REQ_START && m_axis_tready |=> !m_axis_tvalid)
        else $error("pixel produced by a start request");

    // A step on a line with pixels left always yields a pixel.
    a_step_yields_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept && s_axis_tuser == REQ_STEP && r_busy |=> m_axis_tvalid)
        else $error("step request on a busy line lost its pixel");

    // A rising steep line never stands on or past its end row while busy.
    a_steep_up_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && r_region == REG_STEEP_UP |-> r_cur_y < r_goal_y)
        else $error("steep rising line overran its end row");

endmodule
